### sv/sfa_pkg.sv
package sfa_pkg;

    // Slab geometry.
    localparam int PAGE_BYTES     = 4096;
    localparam int BIG_SLAB_PAGES = 4;
    localparam int CONTROL_BYTES  = 48;
    localparam int MAX_BLOCKS     = 2048;

    // Field widths.
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 16;
    localparam int ALIGN_W  = 13;
    localparam int STRIDE_W = 17;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W    = $clog2(MAX_BLOCKS);

    // Largest distance from the aligned start to the control bytes.
    localparam int SPAN_W = $clog2(BIG_SLAB_PAGES * PAGE_BYTES + 1);
    // Largest offset of a block address from the first block.
    localparam int OFF_W  = STRIDE_W + IDX_W;
    localparam int PROD_W = STRIDE_W + CNT_W;
    localparam int NB_W   = $clog2(ADDR_W + 1);

    // A block size up to this fits a one-page slab.
    localparam int SMALL_MAX = PAGE_BYTES / 8;

    // Configuration port.
    localparam int CFG_W     = ADDR_W;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT   = 2'd2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  region_base;
        logic [SIZE_W-1:0]  block_size;
        logic [ALIGN_W-1:0] alignment;
    } cfg_t;

    typedef struct packed {
        logic                start;
        logic [NB_W-1:0]     nbits;
        logic [ADDR_W-1:0]   dividend;
        logic [STRIDE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [ADDR_W-1:0]   quotient;
        logic [STRIDE_W-1:0] remainder;
    } div_rsp_t;

endpackage

### sv/sfa_front.sv
module sfa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [sfa_pkg::CMD_W-1:0]     cmd,
    input  logic [sfa_pkg::ADDR_W-1:0]    block_address,
    output logic                          item_valid,
    output sfa_pkg::item_t                item,
    input  logic                          take
);
    import sfa_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;
    item_t      in_item;

    // Classify the command as it comes in.
    always_comb
    begin
        in_item.addr = block_address;
        case (cmd)
            CMD_INIT:  in_item.op = OP_INIT;
            CMD_ALLOC: in_item.op = OP_ALLOC;
            CMD_FREE:  in_item.op = OP_FREE;
            default:   in_item.op = OP_NOP;
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = take && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### sv/sfa_div.sv
module sfa_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sfa_pkg::div_req_t req,
    output sfa_pkg::div_rsp_t rsp
);
    import sfa_pkg::*;

    logic [ADDR_W-1:0]   dvd_reg, dvd_next;
    logic [ADDR_W-1:0]   quo_reg, quo_next;
    logic [STRIDE_W-1:0] rem_reg, rem_next;
    logic [STRIDE_W-1:0] dsr_reg, dsr_next;
    logic [NB_W-1:0]     cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [STRIDE_W:0]   trial;
    logic [STRIDE_W:0]   diff;
    logic [NB_W-1:0]     shamt;

    // Restoring long division, one dividend bit per cycle. The dividend is
    // left-justified so that only its low nbits bits are walked through.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[ADDR_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        shamt     = NB_W'(ADDR_W) - req.nbits;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next = req.dividend << shamt;
            quo_next = '0;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = req.nbits;
        end
        else if (cnt_reg != '0)
        begin
            // The sign of the trial difference tells whether the divisor fits.
            if (!diff[STRIDE_W])
            begin
                rem_next = diff[STRIDE_W-1:0];
            end
            else
            begin
                rem_next = trial[STRIDE_W-1:0];
            end
            quo_next  = {quo_reg[ADDR_W-2:0], !diff[STRIDE_W]};
            dvd_next  = dvd_reg << 1;
            cnt_next  = cnt_reg - NB_W'(1);
            done_next = (cnt_reg == NB_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### sv/sfa_engine.sv
module sfa_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  sfa_pkg::item_t                item,
    output logic                          take,
    input  sfa_pkg::cfg_t                 cfg,
    input  logic                          pop,
    output logic                          res_valid,
    output logic [sfa_pkg::ADDR_W-1:0]    result_address,
    output logic [sfa_pkg::CNT_W-1:0]     blocks_free,
    output logic [sfa_pkg::STATUS_W-1:0]  status
);
    import sfa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE        = 8'b00000001,
        S_ALLOC       = 8'b00000010,
        S_FREE_DIV    = 8'b00000100,
        S_INIT_BS     = 8'b00001000,
        S_INIT_BASE   = 8'b00010000,
        S_INIT_LAYOUT = 8'b00100000,
        S_INIT_CNT    = 8'b01000000,
        S_FILL        = 8'b10000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    free_total_reg, free_total_next;
    logic [CNT_W-1:0]    block_total_reg, block_total_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [ADDR_W-1:0]   first_reg, first_next;
    logic [ADDR_W:0]     limit_reg, limit_next;
    logic [ADDR_W:0]     start_reg, start_next;
    logic [ADDR_W:0]     end_reg, end_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;

    logic                    res_valid_reg, res_valid_next;
    logic [ADDR_W-1:0]       res_addr_reg, res_addr_next;
    logic [CNT_W-1:0]        res_free_reg, res_free_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                    res_load;

    logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
    logic [CNT_W-1:0] link_rd_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [ALIGN_W-1:0]  al;
    logic [ALIGN_W-1:0]  pad;
    logic [STRIDE_W-1:0] stride_raw;
    logic [ADDR_W:0]     ctrl;
    logic                layout_ok;
    logic [ADDR_W:0]     span_diff;
    logic [CNT_W-1:0]    count_sat;
    logic [CNT_W-1:0]    mul_b;
    logic [PROD_W-1:0]   product;
    logic                slot_free;
    logic                free_bad;
    logic                commit;
    logic [CNT_W-1:0]    commit_cnt;

    sfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Shared arithmetic for the init steps and the free range check.
    always_comb
    begin
        al         = (cfg.alignment == '0) ? ALIGN_W'(1) : cfg.alignment;
        pad        = (div_rsp.remainder[ALIGN_W-1:0] == '0) ? '0
                   : al - div_rsp.remainder[ALIGN_W-1:0];
        stride_raw = STRIDE_W'(cfg.block_size) + STRIDE_W'(pad);
        ctrl       = end_reg - (ADDR_W + 1)'(CONTROL_BYTES);
        layout_ok  = (end_reg <= {1'b1, {ADDR_W{1'b0}}}) && (start_reg <= ctrl);
        span_diff  = ctrl - start_reg;
        count_sat  = (div_rsp.quotient > ADDR_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                   : div_rsp.quotient[CNT_W-1:0];
        free_bad   = (item.addr < first_reg) || ({1'b0, item.addr} >= limit_reg)
                   || (free_total_reg >= block_total_reg);
    end

    assign slot_free = !res_valid_reg || pop;
    assign take      = (state_reg == S_IDLE) && item_valid && slot_free;
    assign product   = PROD_W'(stride_reg) * PROD_W'(mul_b);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        free_total_next  = free_total_reg;
        block_total_next = block_total_reg;
        stride_next      = stride_reg;
        first_next       = first_reg;
        limit_next       = limit_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        prod_next        = prod_reg;
        fill_next        = fill_reg;
        mul_b            = head_reg;
        commit           = 1'b0;
        commit_cnt       = '0;
        mem_we           = 1'b0;
        mem_waddr        = fill_reg[IDX_W-1:0];
        mem_wdata        = fill_reg + CNT_W'(1);
        res_load         = 1'b0;
        res_addr_next    = res_addr_reg;
        res_status_next  = res_status_reg;
        div_req.start    = 1'b0;
        div_req.nbits    = NB_W'(OFF_W);
        div_req.dividend = item.addr - first_reg;
        div_req.divisor  = stride_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (item.op)
                        OP_INIT:
                        begin
                            div_req.start    = 1'b1;
                            div_req.nbits    = NB_W'(SIZE_W);
                            div_req.dividend = ADDR_W'(cfg.block_size);
                            div_req.divisor  = STRIDE_W'(al);
                            state_next       = S_INIT_BS;
                        end
                        OP_ALLOC:
                        begin
                            if (free_total_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_addr_next   = '0;
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // The link memory is read at the head this cycle.
                                prod_next  = product;
                                state_next = S_ALLOC;
                            end
                        end
                        OP_FREE:
                        begin
                            if (free_bad)
                            begin
                                res_load        = 1'b1;
                                res_addr_next   = '0;
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = S_FREE_DIV;
                            end
                        end
                        default:
                        begin
                            res_load        = 1'b1;
                            res_addr_next   = '0;
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                res_load        = 1'b1;
                res_addr_next   = first_reg + ADDR_W'(prod_reg);
                res_status_next = ST_OK;
                head_next       = link_rd_reg;
                free_total_next = free_total_reg - CNT_W'(1);
                state_next      = S_IDLE;
            end
            S_FREE_DIV:
            begin
                if (div_rsp.done)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = div_rsp.quotient[IDX_W-1:0];
                    mem_wdata       = head_reg;
                    head_next       = CNT_W'(div_rsp.quotient[IDX_W-1:0]);
                    free_total_next = free_total_reg + CNT_W'(1);
                    res_load        = 1'b1;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_INIT_BS:
            begin
                if (div_rsp.done)
                begin
                    stride_next      = (stride_raw < STRIDE_W'(2)) ? STRIDE_W'(2) : stride_raw;
                    div_req.start    = 1'b1;
                    div_req.nbits    = NB_W'(ADDR_W);
                    div_req.dividend = cfg.region_base;
                    div_req.divisor  = STRIDE_W'(al);
                    state_next       = S_INIT_BASE;
                end
            end
            S_INIT_BASE:
            begin
                if (div_rsp.done)
                begin
                    start_next = {1'b0, cfg.region_base} + (ADDR_W + 1)'(pad);
                    if (cfg.block_size <= SIZE_W'(SMALL_MAX))
                    begin
                        end_next = {1'b0, cfg.region_base} + (ADDR_W + 1)'(PAGE_BYTES);
                    end
                    else
                    begin
                        end_next = {1'b0, cfg.region_base}
                                 + (ADDR_W + 1)'(BIG_SLAB_PAGES * PAGE_BYTES);
                    end
                    state_next = S_INIT_LAYOUT;
                end
            end
            S_INIT_LAYOUT:
            begin
                if (layout_ok)
                begin
                    div_req.start    = 1'b1;
                    div_req.nbits    = NB_W'(SPAN_W);
                    div_req.dividend = span_diff[ADDR_W-1:0];
                    div_req.divisor  = stride_reg;
                    state_next       = S_INIT_CNT;
                end
                else
                begin
                    commit = 1'b1;
                end
            end
            S_INIT_CNT:
            begin
                if (div_rsp.done)
                begin
                    commit     = 1'b1;
                    commit_cnt = count_sat;
                end
            end
            S_FILL:
            begin
                // Link every block to the next one, one entry a cycle.
                if (fill_reg == block_total_reg)
                begin
                    limit_next      = {1'b0, first_reg} + (ADDR_W + 1)'(prod_reg);
                    res_load        = 1'b1;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            mul_b            = commit_cnt;
            prod_next        = product;
            block_total_next = commit_cnt;
            free_total_next  = commit_cnt;
            head_next        = '0;
            first_next       = start_reg[ADDR_W-1:0];
            fill_next        = '0;
            state_next       = S_FILL;
        end

        res_free_next  = res_load ? free_total_next : res_free_reg;
        res_valid_next = res_load || (res_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            free_total_reg  <= '0;
            block_total_reg <= '0;
            stride_reg      <= STRIDE_W'(2);
            first_reg       <= '0;
            limit_reg       <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            free_total_reg  <= free_total_next;
            block_total_reg <= block_total_next;
            stride_reg      <= stride_next;
            first_reg       <= first_next;
            limit_reg       <= limit_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        end_reg        <= end_next;
        prod_reg       <= prod_next;
        fill_reg       <= fill_next;
        res_addr_reg   <= res_addr_next;
        res_free_reg   <= res_free_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
    end

    assign res_valid      = res_valid_reg;
    assign result_address = res_addr_reg;
    assign blocks_free    = res_free_reg;
    assign status         = res_status_reg;

endmodule

### sv/slab_free_list_block_allocator.sv
// Free-list allocator for one slab of fixed-size blocks. Words go in through
// a two-deep command queue and results come out of a one-word result
// register; the engine starts a new word once the previous result is taken
// or is being popped. Allocate reads the link memory, then adds the
// address. Free runs through the bit-serial divider that turns the 28-bit
// address offset into a block index. Init uses the divider to round the
// block size and the region base up to the alignment and to count the
// blocks, then links the free list in the link memory block by block, for
// up to 2048 blocks. An unused command and a refused allocate or free are
// answered straight from the idle state. The link memory is not cleared
// after reset; an allocate before any init reports an empty slab.
module slab_free_list_block_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [sfa_pkg::CMD_W-1:0]      cmd,
    input  logic [sfa_pkg::ADDR_W-1:0]     block_address,
    output logic                           empty,
    input  logic                           pop,
    output logic [sfa_pkg::ADDR_W-1:0]     result_address,
    output logic [sfa_pkg::CNT_W-1:0]      blocks_free,
    output logic [sfa_pkg::STATUS_W-1:0]   status,
    input  logic                           cfg_write,
    input  logic [sfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfa_pkg::CFG_W-1:0]      cfg_data
);
    import sfa_pkg::*;

    logic [ADDR_W-1:0]  region_base_reg, region_base_next;
    logic [SIZE_W-1:0]  block_size_reg, block_size_next;
    logic [ALIGN_W-1:0] alignment_reg, alignment_next;
    cfg_t               cfg;
    logic               item_valid;
    item_t              item;
    logic               take;
    logic               res_valid;

    always_comb
    begin
        region_base_next = region_base_reg;
        block_size_next  = block_size_reg;
        alignment_next   = alignment_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_REGION_BASE: region_base_next = cfg_data[ADDR_W-1:0];
                REG_BLOCK_SIZE:  block_size_next  = cfg_data[SIZE_W-1:0];
                REG_ALIGNMENT:   alignment_next   = cfg_data[ALIGN_W-1:0];
                default:         region_base_next = region_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            block_size_reg  <= SIZE_W'(16);
            alignment_reg   <= ALIGN_W'(1);
        end
        else
        begin
            region_base_reg <= region_base_next;
            block_size_reg  <= block_size_next;
            alignment_reg   <= alignment_next;
        end
    end

    assign cfg.region_base = region_base_reg;
    assign cfg.block_size  = block_size_reg;
    assign cfg.alignment   = alignment_reg;

    sfa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .block_address (block_address),
        .item_valid    (item_valid),
        .item          (item),
        .take          (take)
    );

    sfa_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .take           (take),
        .cfg            (cfg),
        .pop            (pop),
        .res_valid      (res_valid),
        .result_address (result_address),
        .blocks_free    (blocks_free),
        .status         (status)
    );

    assign empty = !res_valid;

`ifndef SYNTH
    // A refused allocate reports no address and an empty list.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_EMPTY) |-> (result_address == '0 && blocks_free == '0))
        else $error("empty-slab result carries an address or free blocks");

    // Only a successful allocate hands out an address.
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_address != '0) |-> (status == ST_OK))
        else $error("address returned with a failure status");

    // The free count never passes the slab's capacity.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (blocks_free <= CNT_W'(MAX_BLOCKS)))
        else $error("free block count exceeds capacity");

    // The engine does not take a word while the result register stays full.
    a_take_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !empty) |-> pop)
        else $error("word taken while result register is held");
`endif

endmodule
